// File: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared constants: tick width, op codes, bus phases, registers, header steps.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TickWidth = 10;

    localparam logic [TickWidth-1:0] HalfBitReset = TickWidth'(5);

    localparam logic [2:0] OpTick      = 3'd0;
    localparam logic [2:0] OpStart     = 3'd1;
    localparam logic [2:0] OpStop      = 3'd2;
    localparam logic [2:0] OpWrite     = 3'd3;
    localparam logic [2:0] OpReadAck   = 3'd4;
    localparam logic [2:0] OpReadNack  = 3'd5;
    localparam logic [2:0] OpHeader    = 3'd6;

    localparam logic [3:0] PhIdle      = 4'd0;
    localparam logic [3:0] PhStartRel  = 4'd1;
    localparam logic [3:0] PhStartHigh = 4'd2;
    localparam logic [3:0] PhStartLow  = 4'd3;
    localparam logic [3:0] PhStopLow   = 4'd4;
    localparam logic [3:0] PhStopHigh  = 4'd5;
    localparam logic [3:0] PhStopRel   = 4'd6;
    localparam logic [3:0] PhBitLow    = 4'd7;
    localparam logic [3:0] PhBitHigh   = 4'd8;

    localparam logic [0:0] RegDeviceAddress = 1'b0;
    localparam logic [0:0] RegHalfBitTicks  = 1'b1;

    localparam logic [3:0] BitsPerByte = 4'd8;

    localparam logic [1:0] HdrNone = 2'd0;
    localparam logic [1:0] HdrAddr = 2'd1;
    localparam logic [1:0] HdrWord = 2'd2;

endpackage

// File: src/i2c_master_byte_engine_top.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Each input transfer is one timing tick with an SDA sample. The engine
// updates its bus phase, bit counter and shift register in one pass and
// returns the SCL level, SDA drive and status for that tick.
// ----------------------------------------------------------------------------
// The engine takes one tick per clock unless the output stalls, and returns
// exactly one result transfer per tick, in the cycle after the tick is taken.
// The result waits in an output register; a new tick is taken whenever
// that register is empty or is being read out in the same cycle, so a steady
// stream runs at one tick per clock. Commands are started only on a tick
// that begins idle; while one runs, each tick's operation field is ignored.
module i2c_master_byte_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_data_byte,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_release,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_data,
    output logic       o_slave_acked,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [i2cm_pkg::TickWidth-1:0] i_cfg_data
);
    import i2cm_pkg::*;

    logic [7:0]           r_device_address;
    logic [TickWidth-1:0] r_half_bit_ticks;

    logic [3:0]           r_phase,       n_phase;
    logic [3:0]           r_bit_count,   n_bit_count;
    logic [7:0]           r_shift_reg,   n_shift_reg;
    logic [TickWidth-1:0] r_tick_count,  n_tick_count;
    logic [1:0]           r_header_step, n_header_step;
    logic [2:0]           r_pending_op,  n_pending_op;
    logic                 r_ack_flag,    n_ack_flag;
    logic [7:0]           r_word_addr,   n_word_addr;
    logic [7:0]           r_rd_byte,     n_rd_byte;
    logic                 r_scl,         n_scl;
    logic                 r_sda,         n_sda;
    logic                 n_done;

    logic                 r_out_valid;
    logic                 r_out_scl;
    logic                 r_out_sda;
    logic                 r_out_busy;
    logic                 r_out_done;
    logic [7:0]           r_out_read_data;
    logic                 r_out_acked;

    logic                 w_in_accept;
    logic [TickWidth-1:0] w_half;
    logic [TickWidth-1:0] w_tick_inc;

    function automatic logic f_bit_low_sda(input logic [3:0] bit_count,
                                           input logic       shift_msb,
                                           input logic [2:0] pending_op);
        logic is_read;
        is_read = (pending_op == OpReadAck) || (pending_op == OpReadNack);
        if (bit_count < BitsPerByte) begin
            f_bit_low_sda = is_read ? 1'b1 : shift_msb;
        end else begin
            f_bit_low_sda = (pending_op == OpReadAck) ? 1'b0 : 1'b1;
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    assign w_half     = (r_half_bit_ticks == '0) ? TickWidth'(1) : r_half_bit_ticks;
    assign w_tick_inc = r_tick_count + TickWidth'(1);

    always_comb begin
        logic is_read;
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shift_reg   = r_shift_reg;
        n_tick_count  = r_tick_count;
        n_header_step = r_header_step;
        n_pending_op  = r_pending_op;
        n_ack_flag    = r_ack_flag;
        n_word_addr   = r_word_addr;
        n_rd_byte     = r_rd_byte;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_done        = 1'b0;
        is_read = (r_pending_op == OpReadAck) || (r_pending_op == OpReadNack);

        if (r_phase != PhIdle) begin
            n_tick_count = w_tick_inc;
            if (w_tick_inc >= w_half) begin
                n_tick_count = '0;
                unique case (r_phase)
                    PhStartRel: begin
                        n_phase = PhStartHigh;
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                    end
                    PhStartHigh: begin
                        n_phase = PhStartLow;
                        n_sda   = 1'b0;
                    end
                    PhStartLow: begin
                        n_scl = 1'b0;
                        if (r_pending_op == OpHeader) begin
                            n_header_step = HdrAddr;
                            n_shift_reg   = r_device_address;
                            n_bit_count   = '0;
                            n_phase       = PhBitLow;
                            n_sda         = f_bit_low_sda(4'd0, r_device_address[7],
                                                          r_pending_op);
                        end else begin
                            n_phase = PhIdle;
                            n_done  = 1'b1;
                        end
                    end
                    PhStopLow: begin
                        n_phase = PhStopHigh;
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                    end
                    PhStopHigh: begin
                        n_phase = PhStopRel;
                        n_sda   = 1'b1;
                    end
                    PhStopRel: begin
                        n_phase = PhIdle;
                        n_done  = 1'b1;
                    end
                    PhBitLow: begin
                        n_phase = PhBitHigh;
                        n_scl   = 1'b1;
                    end
                    PhBitHigh: begin
                        if (r_bit_count < BitsPerByte) begin
                            n_shift_reg = {r_shift_reg[6:0], is_read ? i_sda_in : 1'b0};
                            n_bit_count = r_bit_count + 4'd1;
                            n_phase     = PhBitLow;
                            n_scl       = 1'b0;
                            n_sda       = f_bit_low_sda(n_bit_count, n_shift_reg[7],
                                                        r_pending_op);
                        end else if (is_read) begin
                            n_rd_byte = r_shift_reg;
                            n_scl     = 1'b0;
                            n_sda     = 1'b1;
                            n_phase   = PhIdle;
                            n_done    = 1'b1;
                        end else begin
                            n_ack_flag = !i_sda_in;
                            if (i_sda_in) begin
                                n_header_step = HdrNone;
                                n_phase       = PhStopLow;
                                n_scl         = 1'b0;
                                n_sda         = 1'b0;
                            end else if (r_pending_op == OpHeader &&
                                         r_header_step == HdrAddr) begin
                                n_header_step = HdrWord;
                                n_shift_reg   = r_word_addr;
                                n_bit_count   = '0;
                                n_phase       = PhBitLow;
                                n_scl         = 1'b0;
                                n_sda         = f_bit_low_sda(4'd0, r_word_addr[7],
                                                              r_pending_op);
                            end else begin
                                n_header_step = HdrNone;
                                n_scl         = 1'b0;
                                n_sda         = 1'b1;
                                n_phase       = PhIdle;
                                n_done        = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PhIdle;
                    end
                endcase
            end
        end else begin
            n_pending_op = i_operation;
            n_tick_count = '0;
            n_bit_count  = '0;
            unique case (i_operation)
                OpStart, OpHeader: begin
                    n_word_addr   = i_data_byte;
                    n_header_step = HdrNone;
                    n_phase       = PhStartRel;
                    n_sda         = 1'b1;
                end
                OpStop: begin
                    n_phase = PhStopLow;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                end
                OpWrite: begin
                    n_shift_reg = i_data_byte;
                    n_phase     = PhBitLow;
                    n_scl       = 1'b0;
                    n_sda       = f_bit_low_sda(4'd0, i_data_byte[7], i_operation);
                end
                OpReadAck, OpReadNack: begin
                    n_shift_reg = '0;
                    n_phase     = PhBitLow;
                    n_scl       = 1'b0;
                    n_sda       = f_bit_low_sda(4'd0, 1'b0, i_operation);
                end
                default: begin
                    n_pending_op = OpTick;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= '0;
            r_half_bit_ticks <= HalfBitReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                RegDeviceAddress: r_device_address <= i_cfg_data[7:0];
                RegHalfBitTicks:  r_half_bit_ticks <= i_cfg_data;
                default:          r_device_address <= r_device_address;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PhIdle;
            r_bit_count   <= '0;
            r_shift_reg   <= '0;
            r_tick_count  <= '0;
            r_header_step <= HdrNone;
            r_pending_op  <= OpTick;
            r_ack_flag    <= 1'b0;
            r_word_addr   <= '0;
            r_rd_byte     <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
        end else if (w_in_accept) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_shift_reg   <= n_shift_reg;
            r_tick_count  <= n_tick_count;
            r_header_step <= n_header_step;
            r_pending_op  <= n_pending_op;
            r_ack_flag    <= n_ack_flag;
            r_word_addr   <= n_word_addr;
            r_rd_byte     <= n_rd_byte;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out_scl       <= n_scl;
            r_out_sda       <= n_sda;
            r_out_busy      <= (n_phase != PhIdle);
            r_out_done      <= n_done;
            r_out_read_data <= n_rd_byte;
            r_out_acked     <= n_ack_flag;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_out_scl;
    assign o_sda_release = r_out_sda;
    assign o_busy_res    = r_out_busy;
    assign o_done_res    = r_out_done;
    assign o_read_data   = r_out_read_data;
    assign o_slave_acked = r_out_acked;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> !r_out_busy)
        else $error("done reported while still busy");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BitsPerByte)
        else $error("bit counter past the acknowledge bit");

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PhIdle) |-> (r_tick_count == '0))
        else $error("tick counter not cleared while idle");

    a_header_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_header_step != 2'd3))
        else $error("invalid header step");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_out_valid)
        else $error("tick taken without a result");

endmodule
